### hw/rtl/tds_pkg.sv
// Shared types and constants of the tape directory slot scanner.
`timescale 1ns / 1ps

package tds_pkg;

    // Container layout
    localparam int unsigned HEADER_BYTES = 64;
    localparam int unsigned SLOT_BYTES   = 32;
    localparam int unsigned OFFSET_WIDTH = 32;
    localparam int unsigned SLOT_SHIFT   = $clog2(SLOT_BYTES);

    // Field and state widths
    localparam int unsigned TYPE_WIDTH    = 8;
    localparam int unsigned ADDR_WIDTH    = 16;
    localparam int unsigned LENGTH_WIDTH  = 17;
    localparam int unsigned COUNT_WIDTH   = 16;
    localparam int unsigned COUNTER_WIDTH = 17;
    localparam int unsigned POS_WIDTH     = COUNTER_WIDTH + SLOT_SHIFT + 1;

    // Slot type codes
    localparam logic [TYPE_WIDTH-1:0] TYPE_FREE       = 8'd0;
    localparam logic [TYPE_WIDTH-1:0] TYPE_LAST_VALID = 8'd5;

    // Configuration port
    localparam int unsigned APB_ADDR_WIDTH = 3;
    localparam int unsigned APB_DATA_WIDTH = 32;
    localparam logic REG_CONTAINER_BYTES = 1'b0;
    localparam logic REG_HEADER_SLOTS    = 1'b1;

    typedef enum logic [2:0] {
        VERDICT_FREE      = 3'd0,
        VERDICT_SKIPPED   = 3'd1,
        VERDICT_TRUNCATED = 3'd2,
        VERDICT_ACCEPTED  = 3'd3,
        VERDICT_STOPPED   = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [OFFSET_WIDTH-1:0] container_bytes;
        logic [COUNT_WIDTH-1:0]  header_slot_count;
    } cfg_t;

    typedef struct packed {
        logic                    scan_begin;
        logic [TYPE_WIDTH-1:0]   slot_type;
        logic [ADDR_WIDTH-1:0]   load_start;
        logic [ADDR_WIDTH-1:0]   load_end;
        logic [OFFSET_WIDTH-1:0] data_position;
    } slot_t;

    typedef struct packed {
        verdict_t                verdict;
        logic [COUNT_WIDTH-1:0]  slot_number;
        logic [LENGTH_WIDTH-1:0] declared_length;
        logic                    length_impossible;
        logic [OFFSET_WIDTH-1:0] lowest_data;
        logic [COUNT_WIDTH-1:0]  accepted_total;
        logic [COUNT_WIDTH-1:0]  skipped_total;
        logic [COUNT_WIDTH-1:0]  truncated_total;
    } result_t;

    // Control from the pipeline to the classifier
    typedef struct packed {
        logic fire;
    } core_ctrl_t;

endpackage

### hw/rtl/tds_if.sv
// Valid/ready channel interfaces for directory slots and scan results.
`timescale 1ns / 1ps

interface tds_slot_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 scan_begin;
    logic [tds_pkg::TYPE_WIDTH-1:0]       slot_type;
    logic [tds_pkg::ADDR_WIDTH-1:0]       load_start;
    logic [tds_pkg::ADDR_WIDTH-1:0]       load_end;
    logic [tds_pkg::OFFSET_WIDTH-1:0]     data_position;

    modport source (
        output valid, scan_begin, slot_type, load_start, load_end, data_position,
        input  ready
    );
    modport sink (
        input  valid, scan_begin, slot_type, load_start, load_end, data_position,
        output ready
    );
endinterface

interface tds_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [2:0]                           verdict;
    logic [tds_pkg::COUNT_WIDTH-1:0]      slot_number;
    logic [tds_pkg::LENGTH_WIDTH-1:0]     declared_length;
    logic                                 length_impossible;
    logic [tds_pkg::OFFSET_WIDTH-1:0]     lowest_data;
    logic [tds_pkg::COUNT_WIDTH-1:0]      accepted_total;
    logic [tds_pkg::COUNT_WIDTH-1:0]      skipped_total;
    logic [tds_pkg::COUNT_WIDTH-1:0]      truncated_total;

    modport source (
        output valid, verdict, slot_number, declared_length, length_impossible,
               lowest_data, accepted_total, skipped_total, truncated_total,
        input  ready
    );
    modport sink (
        input  valid, verdict, slot_number, declared_length, length_impossible,
               lowest_data, accepted_total, skipped_total, truncated_total,
        output ready
    );
endinterface

### hw/rtl/tape_directory_slot_scanner.sv
// Top level of the tape directory slot scanner.
`timescale 1ns / 1ps

// Tape directory slot scanner.
// Slots arrive on the slot channel (valid/ready), one decoded directory entry
// per transfer, in slot order; a transfer with scan_begin set starts a new
// scan at slot zero. Every slot yields exactly one transfer on the result
// channel with its verdict, its slot number, its declared length and the
// running lowest data offset and counts after it.
// Container size and header slot count are written on the APB port (byte
// addresses 0 and 4); the user must write them only while no slot is in
// flight, the block does not enforce it; they apply from the next slot on.
// Path: a slot that is taken sits in the input register; it is classified and
// lands in the result register as soon as the result register is free, and
// its result is then offered on the result channel.
// Throughput: one slot per cycle while the receiver takes results, set by the
// combinational classifier between the input register and the result
// register; the scan state feeds back in that same cycle.
// Reset clears the valid flags of both registers and the scan state; slots
// before the first scan begin are stopped. A stalled receiver holds the
// result; the input register still takes one more slot, then ready drops.
module tape_directory_slot_scanner (
    input  logic                                clk,
    input  logic                                rst_n,
    tds_slot_if.sink                            slot,
    tds_result_if.source                        result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tds_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [tds_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [tds_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                pready
);

    tds_pkg::cfg_t       cfg;
    tds_pkg::slot_t      slot_item_reg;
    logic                slot_valid_reg;
    tds_pkg::result_t    result_data_reg;
    logic                result_valid_reg;
    tds_pkg::result_t    core_res;
    tds_pkg::core_ctrl_t ctrl;
    logic                advance;
    logic                slot_take;

    tds_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: move a slot forward whenever the result register can take it
    assign advance    = !result_valid_reg || result.ready;
    assign ctrl.fire  = slot_valid_reg && advance;
    assign slot.ready = !slot_valid_reg || advance;
    assign slot_take  = slot.valid && slot.ready;

    // Hold the incoming slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_valid_reg <= 1'b0;
        else if (slot_take)
            slot_valid_reg <= 1'b1;
        else if (ctrl.fire)
            slot_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (slot_take)
        begin
            slot_item_reg.scan_begin    <= slot.scan_begin;
            slot_item_reg.slot_type     <= slot.slot_type;
            slot_item_reg.load_start    <= slot.load_start;
            slot_item_reg.load_end      <= slot.load_end;
            slot_item_reg.data_position <= slot.data_position;
        end
    end

    tds_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .item  (slot_item_reg),
        .ctrl  (ctrl),
        .res   (core_res)
    );

    // Register the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= slot_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fire)
            result_data_reg <= core_res;
    end

    assign result.valid             = result_valid_reg;
    assign result.verdict           = result_data_reg.verdict;
    assign result.slot_number       = result_data_reg.slot_number;
    assign result.declared_length   = result_data_reg.declared_length;
    assign result.length_impossible = result_data_reg.length_impossible;
    assign result.lowest_data       = result_data_reg.lowest_data;
    assign result.accepted_total    = result_data_reg.accepted_total;
    assign result.skipped_total     = result_data_reg.skipped_total;
    assign result.truncated_total   = result_data_reg.truncated_total;

endmodule

### hw/rtl/tds_regs.sv
// APB configuration registers of the slot scanner.
`timescale 1ns / 1ps

module tds_regs (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [tds_pkg::APB_ADDR_WIDTH-1:0]     paddr,
    input  logic [tds_pkg::APB_DATA_WIDTH-1:0]     pwdata,
    output logic [tds_pkg::APB_DATA_WIDTH-1:0]     prdata,
    output logic                                   pready,
    output tds_pkg::cfg_t                          cfg
);

    logic [tds_pkg::OFFSET_WIDTH-1:0] container_bytes_reg;
    logic [tds_pkg::COUNT_WIDTH-1:0]  header_slot_count_reg;
    logic                             wr_en;
    logic                             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    // Write on the access phase of a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            container_bytes_reg   <= '0;
            header_slot_count_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                tds_pkg::REG_CONTAINER_BYTES:
                    container_bytes_reg <= pwdata[tds_pkg::OFFSET_WIDTH-1:0];
                tds_pkg::REG_HEADER_SLOTS:
                    header_slot_count_reg <= pwdata[tds_pkg::COUNT_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_sel)
            tds_pkg::REG_CONTAINER_BYTES:
                prdata = tds_pkg::APB_DATA_WIDTH'(container_bytes_reg);
            tds_pkg::REG_HEADER_SLOTS:
                prdata = tds_pkg::APB_DATA_WIDTH'(header_slot_count_reg);
            default:
                prdata = '0;
        endcase
    end

    assign cfg.container_bytes   = container_bytes_reg;
    assign cfg.header_slot_count = header_slot_count_reg;

endmodule

### hw/rtl/tds_core.sv
// Slot classifier: scan state, length check, verdict and running counts.
`timescale 1ns / 1ps

module tds_core (
    input  logic                clk,
    input  logic                rst_n,
    input  tds_pkg::cfg_t       cfg,
    input  tds_pkg::slot_t      item,
    input  tds_pkg::core_ctrl_t ctrl,
    output tds_pkg::result_t    res
);

    localparam int unsigned CW = tds_pkg::COUNTER_WIDTH;
    localparam int unsigned NW = tds_pkg::COUNT_WIDTH;
    localparam int unsigned OW = tds_pkg::OFFSET_WIDTH;
    localparam int unsigned PW = tds_pkg::POS_WIDTH;
    localparam int unsigned LW = tds_pkg::LENGTH_WIDTH;

    logic [CW-1:0] slot_counter_reg, slot_counter_next;
    logic [OW-1:0] lowest_reg, lowest_next;
    logic          halted_reg, halted_next;
    logic [NW-1:0] accepted_reg, accepted_next;
    logic [NW-1:0] skipped_reg, skipped_next;
    logic [NW-1:0] truncated_reg, truncated_next;

    logic [CW-1:0] cur_counter;
    logic [OW-1:0] cur_lowest;
    logic          cur_halted;
    logic [NW-1:0] cur_accepted;
    logic [NW-1:0] cur_skipped;
    logic [NW-1:0] cur_truncated;
    logic [PW-1:0] position;
    logic [PW-1:0] slot_end;
    logic [LW-1:0] declared;
    logic          impossible;
    logic          stop;
    tds_pkg::verdict_t verdict;

    // Apply scan begin ahead of classification
    always_comb
    begin
        if (item.scan_begin)
        begin
            cur_counter   = '0;
            cur_lowest    = cfg.container_bytes;
            cur_halted    = 1'b0;
            cur_accepted  = '0;
            cur_skipped   = '0;
            cur_truncated = '0;
        end
        else
        begin
            cur_counter   = slot_counter_reg;
            cur_lowest    = lowest_reg;
            cur_halted    = halted_reg;
            cur_accepted  = accepted_reg;
            cur_skipped   = skipped_reg;
            cur_truncated = truncated_reg;
        end
    end

    // Declared length from the load addresses
    always_comb
    begin
        declared   = '0;
        impossible = 1'b0;
        if (item.load_end > item.load_start)
            declared = LW'(item.load_end) - LW'(item.load_start);
        else if (item.load_end == '0)
            declared = {1'b1, {(LW-1){1'b0}}} - LW'(item.load_start);
        else if (item.load_end != item.load_start)
            impossible = 1'b1;
    end

    // Directory position of this slot and the end of its entry
    assign position = PW'(tds_pkg::HEADER_BYTES)
                    + PW'({cur_counter, {tds_pkg::SLOT_SHIFT{1'b0}}});
    assign slot_end = position + PW'(tds_pkg::SLOT_BYTES);

    assign stop = cur_halted
               || (cur_counter >= CW'(cfg.header_slot_count))
               || (OW'(position) >= cur_lowest);

    // Classify and update the scan state
    always_comb
    begin
        slot_counter_next = cur_counter;
        lowest_next       = cur_lowest;
        halted_next       = cur_halted;
        accepted_next     = cur_accepted;
        skipped_next      = cur_skipped;
        truncated_next    = cur_truncated;
        if (stop)
        begin
            halted_next = 1'b1;
            verdict     = tds_pkg::VERDICT_STOPPED;
        end
        else
        begin
            if (cur_counter != '1)
                slot_counter_next = cur_counter + 1'b1;
            if (item.slot_type == tds_pkg::TYPE_FREE)
                verdict = tds_pkg::VERDICT_FREE;
            else if (item.slot_type > tds_pkg::TYPE_LAST_VALID
                     || item.data_position < OW'(slot_end))
            begin
                verdict = tds_pkg::VERDICT_SKIPPED;
                if (cur_skipped != '1)
                    skipped_next = cur_skipped + 1'b1;
            end
            else if (item.data_position > cfg.container_bytes
                     || (item.data_position == cfg.container_bytes
                         && (impossible || declared != '0)))
            begin
                verdict = tds_pkg::VERDICT_TRUNCATED;
                if (cur_truncated != '1)
                    truncated_next = cur_truncated + 1'b1;
            end
            else
            begin
                verdict = tds_pkg::VERDICT_ACCEPTED;
                if (cur_accepted != '1)
                    accepted_next = cur_accepted + 1'b1;
                if (item.data_position < cur_lowest)
                    lowest_next = item.data_position;
            end
        end
    end

    // Advance the scan state on each classified slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_counter_reg <= '0;
            lowest_reg       <= '0;
            halted_reg       <= 1'b0;
            accepted_reg     <= '0;
            skipped_reg      <= '0;
            truncated_reg    <= '0;
        end
        else if (ctrl.fire)
        begin
            slot_counter_reg <= slot_counter_next;
            lowest_reg       <= lowest_next;
            halted_reg       <= halted_next;
            accepted_reg     <= accepted_next;
            skipped_reg      <= skipped_next;
            truncated_reg    <= truncated_next;
        end
    end

    assign res.verdict           = verdict;
    assign res.slot_number       = cur_counter[NW-1:0];
    assign res.declared_length   = declared;
    assign res.length_impossible = impossible;
    assign res.lowest_data       = lowest_next;
    assign res.accepted_total    = accepted_next;
    assign res.skipped_total     = skipped_next;
    assign res.truncated_total   = truncated_next;

    // A stop holds until the next scan begin
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (halted_reg && !(ctrl.fire && item.scan_begin)) |=> halted_reg)
        else $error("stop flag dropped without scan begin");

    // A stopped slot leaves the slot counter where it was
    a_stop_holds_counter: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.fire && !item.scan_begin && verdict == tds_pkg::VERDICT_STOPPED)
        |=> $stable(slot_counter_reg))
        else $error("slot counter moved on a stopped slot");

    // An accepted slot always leaves a nonzero accepted count
    a_accept_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.fire && verdict == tds_pkg::VERDICT_ACCEPTED) |=> accepted_reg != '0)
        else $error("accepted slot not counted");

    // The lowest offset only falls within a scan
    a_lowest_falls: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.fire && !item.scan_begin) |=> lowest_reg <= $past(lowest_reg))
        else $error("lowest data offset rose within a scan");

endmodule
